[rtl/core/rcst_pkg.sv]
// ----------------------------------------------------------------------------
// rcst_pkg: shared types and constants of the slot table
// Field widths, status codes, operation classes and the queue item format.
// ----------------------------------------------------------------------------
package rcst_pkg;

    // default configuration
    localparam int ENTRIES_DEF     = 64;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // fixed field widths of the request and response
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int REFCNT_W = 16;

    // request command codes
    localparam logic CMD_OPEN  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_COUNT_FULL = 3'd3,
        ST_KEY_ZERO   = 3'd4
    } t_status;

    // request class decided by the front end
    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_ZERO  = 2'd2
    } t_op;

    // queue item between front and back end
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_item;

    // back end status seen by the front end
    typedef struct packed {
        logic clear_done;
    } t_bk_status;

endpackage

[rtl/core/rcst_req_if.sv]
// ----------------------------------------------------------------------------
// rcst_req_if: request channel
// Valid/ready channel carrying one open or close request.
// ----------------------------------------------------------------------------
interface rcst_req_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [rcst_pkg::KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

[rtl/core/rcst_rsp_if.sv]
// ----------------------------------------------------------------------------
// rcst_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface rcst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rcst_pkg::STATUS_W-1:0] status;
    logic [rcst_pkg::SLOT_W-1:0]   slot;
    logic [rcst_pkg::REFCNT_W-1:0] ref_count;
    logic                          newly_claimed;
    logic                          freed;

    modport source (output valid, output status, output slot, output ref_count,
                    output newly_claimed, output freed, input ready);
    modport sink   (input valid, input status, input slot, input ref_count,
                    input newly_claimed, input freed, output ready);
endinterface

[rtl/core/rcst_ram.sv]
// ----------------------------------------------------------------------------
// rcst_ram: generic simple dual port ram
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rcst_fifo.sv]
// ----------------------------------------------------------------------------
// rcst_fifo: request queue between front and back end
// Small synchronous fifo of classified requests.
// ----------------------------------------------------------------------------
module rcst_fifo #(
    parameter int DEPTH = rcst_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcst_pkg::t_item i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output rcst_pkg::t_item o_rdata,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rcst_pkg::t_item r_data [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_data[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

endmodule

[rtl/core/rcst_front.sv]
// ----------------------------------------------------------------------------
// rcst_front: request front end
// Takes requests, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module rcst_front (
    rcst_req_if.sink             i_req,
    input  rcst_pkg::t_bk_status i_bk_status,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output rcst_pkg::t_item      o_q_item
);

    // requests wait until the clearing pass is over and the queue has room
    assign i_req.ready = i_bk_status.clear_done && !i_q_full;
    assign o_q_push    = i_req.valid && i_req.ready;

    // classify: the reserved key is refused without a table scan
    always_comb begin
        o_q_item.key = i_req.key;
        if (i_req.key == '0) begin
            o_q_item.op = rcst_pkg::OP_ZERO;
        end else if (i_req.command == rcst_pkg::CMD_CLOSE) begin
            o_q_item.op = rcst_pkg::OP_CLOSE;
        end else begin
            o_q_item.op = rcst_pkg::OP_OPEN;
        end
    end

endmodule

[rtl/core/rcst_back.sv]
// ----------------------------------------------------------------------------
// rcst_back: table back end
// Clears the slot memory after reset, then scans it once per nonzero key
// request, writes back the changed slot and holds the response in a register.
// ----------------------------------------------------------------------------
module rcst_back #(
    parameter int ENTRIES     = rcst_pkg::ENTRIES_DEF,
    parameter int COUNT_WIDTH = rcst_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_vld,
    input  rcst_pkg::t_item      i_item,
    output logic                 o_item_pop,
    output rcst_pkg::t_bk_status o_status,
    rcst_rsp_if.source           o_rsp
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int KW    = rcst_pkg::KEY_W;
    localparam int WW    = 1 + COUNT_WIDTH + KW;
    localparam int KEY_L = 0;
    localparam int CNT_L = KW;
    localparam int USED  = WW - 1;
    localparam logic [AW-1:0]          LAST    = AW'(ENTRIES - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_bk_state;

    t_bk_state r_state, n_state;

    // scan control
    logic [AW-1:0] r_idx, n_idx;
    logic          r_issuing, n_issuing;
    logic          r_cmp_vld, n_cmp_vld;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;

    // current request and scan results
    rcst_pkg::t_op           r_op, n_op;
    logic [KW-1:0]           r_key, n_key;
    logic                    r_hit, n_hit;
    logic [AW-1:0]           r_hit_idx, n_hit_idx;
    logic [COUNT_WIDTH-1:0]  r_hit_cnt, n_hit_cnt;
    logic                    r_free, n_free;
    logic [AW-1:0]           r_free_idx, n_free_idx;

    // response register
    logic                          r_rsp_vld, n_rsp_vld;
    rcst_pkg::t_status             r_rsp_status, n_rsp_status;
    logic [rcst_pkg::SLOT_W-1:0]   r_rsp_slot, n_rsp_slot;
    logic [rcst_pkg::REFCNT_W-1:0] r_rsp_cnt, n_rsp_cnt;
    logic                          r_rsp_claimed, n_rsp_claimed;
    logic                          r_rsp_freed, n_rsp_freed;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;
    logic          out_free;

    rcst_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_rsp_vld || o_rsp.ready;

    // sequencer: clear pass, scan, decide and write back
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_issuing     = r_issuing;
        n_cmp_vld     = 1'b0;
        n_cmp_idx     = r_idx;
        n_op          = r_op;
        n_key         = r_key;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_hit_cnt     = r_hit_cnt;
        n_free        = r_free;
        n_free_idx    = r_free_idx;
        n_rsp_vld     = r_rsp_vld;
        n_rsp_status  = r_rsp_status;
        n_rsp_slot    = r_rsp_slot;
        n_rsp_cnt     = r_rsp_cnt;
        n_rsp_claimed = r_rsp_claimed;
        n_rsp_freed   = r_rsp_freed;
        ram_we        = 1'b0;
        ram_waddr     = r_idx;
        ram_wdata     = '0;
        o_item_pop    = 1'b0;

        if (r_rsp_vld && o_rsp.ready) begin
            n_rsp_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_item_vld) begin
                    o_item_pop = 1'b1;
                    n_op       = i_item.op;
                    n_key      = i_item.key;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_idx      = '0;
                    n_issuing  = 1'b1;
                    if (i_item.op == rcst_pkg::OP_ZERO) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle
                if (r_issuing) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    if (r_idx == LAST) begin
                        n_issuing = 1'b0;
                        n_idx     = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // compare the entry read last cycle, lowest index wins
                if (r_cmp_vld) begin
                    if (ram_rdata[USED]) begin
                        if (!r_hit && ram_rdata[KEY_L +: KW] == r_key) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_cmp_idx;
                            n_hit_cnt = ram_rdata[CNT_L +: COUNT_WIDTH];
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_rsp_vld     = 1'b1;
                    n_rsp_status  = rcst_pkg::ST_OK;
                    n_rsp_slot    = '0;
                    n_rsp_cnt     = '0;
                    n_rsp_claimed = 1'b0;
                    n_rsp_freed   = 1'b0;
                    n_state       = S_IDLE;
                    case (r_op)
                        rcst_pkg::OP_OPEN: begin
                            if (r_hit) begin
                                n_rsp_slot = rcst_pkg::SLOT_W'(r_hit_idx);
                                if (r_hit_cnt == CNT_MAX) begin
                                    n_rsp_status = rcst_pkg::ST_COUNT_FULL;
                                    n_rsp_cnt    = rcst_pkg::REFCNT_W'(r_hit_cnt);
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_hit_idx;
                                    ram_wdata = {1'b1, r_hit_cnt + 1'b1, r_key};
                                    n_rsp_cnt = rcst_pkg::REFCNT_W'(r_hit_cnt + 1'b1);
                                end
                            end else if (r_free) begin
                                // claim the lowest free slot
                                ram_we        = 1'b1;
                                ram_waddr     = r_free_idx;
                                ram_wdata     = {1'b1, CNT_ONE, r_key};
                                n_rsp_slot    = rcst_pkg::SLOT_W'(r_free_idx);
                                n_rsp_cnt     = rcst_pkg::REFCNT_W'(CNT_ONE);
                                n_rsp_claimed = 1'b1;
                            end else begin
                                n_rsp_status = rcst_pkg::ST_FULL;
                            end
                        end
                        rcst_pkg::OP_CLOSE: begin
                            if (!r_hit) begin
                                n_rsp_status = rcst_pkg::ST_NOT_FOUND;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = r_hit_idx;
                                n_rsp_slot = rcst_pkg::SLOT_W'(r_hit_idx);
                                if (r_hit_cnt > CNT_ONE) begin
                                    ram_wdata = {1'b1, r_hit_cnt - 1'b1, r_key};
                                    n_rsp_cnt = rcst_pkg::REFCNT_W'(r_hit_cnt - 1'b1);
                                end else begin
                                    // last reference gone: free the slot
                                    ram_wdata   = '0;
                                    n_rsp_freed = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_rsp_status = rcst_pkg::ST_KEY_ZERO;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_issuing <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_issuing <= n_issuing;
            r_cmp_vld <= n_cmp_vld;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx     <= n_cmp_idx;
        r_op          <= n_op;
        r_key         <= n_key;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_hit_cnt     <= n_hit_cnt;
        r_free        <= n_free;
        r_free_idx    <= n_free_idx;
        r_rsp_status  <= n_rsp_status;
        r_rsp_slot    <= n_rsp_slot;
        r_rsp_cnt     <= n_rsp_cnt;
        r_rsp_claimed <= n_rsp_claimed;
        r_rsp_freed   <= n_rsp_freed;
    end

    assign o_status.clear_done = (r_state != S_CLEAR);

    // response channel
    assign o_rsp.valid         = r_rsp_vld;
    assign o_rsp.status        = r_rsp_status;
    assign o_rsp.slot          = r_rsp_slot;
    assign o_rsp.ref_count     = r_rsp_cnt;
    assign o_rsp.newly_claimed = r_rsp_claimed;
    assign o_rsp.freed         = r_rsp_freed;

endmodule

[rtl/core/refcounted_id_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// refcounted_id_slot_table_unit: reference counted key slot table
// Open and close requests on a table of keyed slots with reference counts.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-------------------------------------------
//   i_req   | in  | valid / ready | command, key
//   o_rsp   | out | valid / ready | status, slot, ref_count, newly_claimed,
//           |     |               | freed
//
// each request is scanned with one registered memory read per slot, then
// decided and written back once the response register is free; a key zero
// request skips the scan
// after reset a clearing pass zeroes the slot memory one slot at a time and
// i_req.ready stays low until it is over
// a queue of two requests sits between the front end and the scan engine,
// and the engine can scan the next request while a response is stalled
// ----------------------------------------------------------------------------
module refcounted_id_slot_table_unit #(
    parameter int ENTRIES     = rcst_pkg::ENTRIES_DEF,
    parameter int COUNT_WIDTH = rcst_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcst_req_if.sink   i_req,
    rcst_rsp_if.source o_rsp
);

    rcst_pkg::t_bk_status bk_status;
    rcst_pkg::t_item      q_wdata;
    rcst_pkg::t_item      q_rdata;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;

    // request classification
    rcst_front u_front (
        .i_req       (i_req),
        .i_bk_status (bk_status),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_wdata)
    );

    // request queue
    rcst_fifo #(
        .DEPTH (rcst_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    // table scan and update
    rcst_back #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_vld (!q_empty),
        .i_item     (q_rdata),
        .o_item_pop (q_pop),
        .o_status   (bk_status),
        .o_rsp      (o_rsp)
    );

endmodule

[rtl/core/rcst_checker.sv]
// ----------------------------------------------------------------------------
// rcst_checker: port level checks of the slot table
// Watches the response channel and its relation to reset and status codes.
// ----------------------------------------------------------------------------
module rcst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [rcst_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [rcst_pkg::SLOT_W-1:0]   i_rsp_slot,
    input logic [rcst_pkg::REFCNT_W-1:0] i_rsp_ref_count,
    input logic                          i_rsp_newly_claimed,
    input logic                          i_rsp_freed
);

    // no response right after reset
    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // a stalled response is not withdrawn
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // a refused zero key reports nothing else
    a_key_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == rcst_pkg::ST_KEY_ZERO |->
        i_rsp_slot == '0 && i_rsp_ref_count == '0 &&
        !i_rsp_newly_claimed && !i_rsp_freed)
        else $error("key zero response carries data");

    // a claim starts at one reference
    a_claim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_newly_claimed |->
        i_rsp_status == rcst_pkg::ST_OK && i_rsp_ref_count == 16'd1 && !i_rsp_freed)
        else $error("claim with wrong count or status");

    // a freed slot ends at zero references
    a_freed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_freed |->
        i_rsp_status == rcst_pkg::ST_OK && i_rsp_ref_count == '0)
        else $error("free with nonzero count or bad status");

endmodule

bind refcounted_id_slot_table_unit rcst_checker u_rcst_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_slot          (o_rsp.slot),
    .i_rsp_ref_count     (o_rsp.ref_count),
    .i_rsp_newly_claimed (o_rsp.newly_claimed),
    .i_rsp_freed         (o_rsp.freed)
);
